@@ src/ema_pkg.sv @@
// Shared types and constants for the multichannel EMA filter.
`timescale 1ns / 1ps

package ema_pkg;

  localparam int CHANNEL_W  = 3;
  localparam int SAMPLE_W   = 16;
  localparam int ALPHA_W    = 7;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam int NUM_SLOTS_MAX = 2 ** CHANNEL_W;
  localparam int COUNT_REG_MAX = 2 ** COUNT_W - 1;

  localparam logic [ALPHA_W-1:0] PERCENT_FULL = 7'd100;

  // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT for x < 2**23
  localparam int                    DIV100_MUL_W = 24;
  localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 24'd10737419;
  localparam int                    DIV100_SHIFT = 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA = 1'b0,
    REG_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_SEED   = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

endpackage

@@ src/ema_if.sv @@
// Valid/ready channel interfaces for sample beats and result beats.
`timescale 1ns / 1ps

interface ema_in_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [ema_pkg::CHANNEL_W-1:0]  channel;
  logic [ema_pkg::SAMPLE_W-1:0]   sample;

  modport source (output valid, operation, channel, sample, input ready);
  modport sink   (input valid, operation, channel, sample, output ready);
endinterface

interface ema_out_if;
  logic                          valid;
  logic                          ready;
  logic                          valid_res;
  logic [ema_pkg::SAMPLE_W-1:0]  raw_value;
  logic [ema_pkg::SAMPLE_W-1:0]  filtered_value;

  modport source (output valid, valid_res, raw_value, filtered_value, input ready);
  modport sink   (input valid, valid_res, raw_value, filtered_value, output ready);
endinterface

@@ src/multichannel_ema_filter_top.sv @@
// Each accepted sample beat passes through the input stage (s1_*) and then the result register.
// Throughput: one beat per cycle unless results.ready is held low, including back-to-back
//   beats on the same channel; the smoothed store is written at the same edge that loads the result register.
// Reset (rst, synchronous): clears both pipeline stages and all smoothed values,
//   new_weight returns to 100 and channel_count to min(CHANNELS, 15).
// Top level of the multichannel EMA filter.
`timescale 1ns / 1ps

module multichannel_ema_filter_top #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  ema_in_if.sink                           samples,
  ema_out_if.source                        results,
  input  logic                             cfg_write,
  input  logic [ema_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ema_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ema_pkg::*;

  localparam int SLOTS     = CHANNELS < NUM_SLOTS_MAX ? CHANNELS : NUM_SLOTS_MAX;
  localparam int IDX_W     = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int COUNT_LIM = CHANNELS < COUNT_REG_MAX ? CHANNELS : COUNT_REG_MAX;
  localparam int ACC_W     = SAMPLE_BITS + ALPHA_W;
  localparam int PROD_W    = ACC_W + DIV100_MUL_W;
  localparam logic [COUNT_W-1:0] COUNT_LIM_V = COUNT_W'(COUNT_LIM);

  // configuration
  logic [ALPHA_W-1:0] new_weight;
  logic [COUNT_W-1:0] channel_count;

  // input stage
  logic                   s1_valid;
  op_t                    s1_op;
  logic [CHANNEL_W-1:0]   s1_channel;
  logic [SAMPLE_BITS-1:0] s1_sample;

  // state and result register
  logic [SAMPLE_BITS-1:0] smoothed_store [SLOTS];
  logic                   out_valid;
  logic                   out_res;
  logic [SAMPLE_W-1:0]    out_raw;
  logic [SAMPLE_W-1:0]    out_filt;

  logic                   advance;
  logic                   slot_ok;
  logic [IDX_W-1:0]       idx;
  logic [SAMPLE_BITS-1:0] old_smooth;
  logic [ACC_W-1:0]       acc;
  logic [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS-1:0] mean;
  logic [SAMPLE_BITS-1:0] new_smooth;

  always_ff @(posedge clk) begin
    if (rst) begin
      new_weight    <= PERCENT_FULL;
      channel_count <= COUNT_LIM_V;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ALPHA: begin
          new_weight <= (cfg_wdata > PERCENT_FULL) ? PERCENT_FULL : cfg_wdata;
        end
        REG_COUNT: begin
          channel_count <= (cfg_wdata[COUNT_W-1:0] > COUNT_LIM_V) ? COUNT_LIM_V
                                                                  : cfg_wdata[COUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign advance       = s1_valid && (!out_valid || results.ready);
  assign samples.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.ready && samples.valid) begin
      s1_op      <= op_t'(samples.operation);
      s1_channel <= samples.channel;
      s1_sample  <= samples.sample[SAMPLE_BITS-1:0];
    end
  end

  // count never exceeds CHANNELS, so this also bounds the store index
  assign slot_ok    = COUNT_W'(s1_channel) < channel_count;
  assign idx        = s1_channel[IDX_W-1:0];
  assign old_smooth = smoothed_store[idx];

  always_comb begin
    acc  = ACC_W'(old_smooth) * ACC_W'(PERCENT_FULL - new_weight)
         + ACC_W'(s1_sample) * ACC_W'(new_weight);
    prod = PROD_W'(acc) * PROD_W'(DIV100_MUL);
    mean = prod[DIV100_SHIFT +: SAMPLE_BITS];
    new_smooth = (s1_op == OP_SEED) ? s1_sample : mean;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        smoothed_store[i] <= '0;
      end
    end else if (advance && slot_ok) begin
      smoothed_store[idx] <= new_smooth;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res  <= slot_ok;
      out_raw  <= slot_ok ? SAMPLE_W'(s1_sample) : '0;
      out_filt <= slot_ok ? SAMPLE_W'(new_smooth) : '0;
    end
  end

  assign results.valid          = out_valid;
  assign results.valid_res      = out_res;
  assign results.raw_value      = out_raw;
  assign results.filtered_value = out_filt;

endmodule

@@ src/ema_checker.sv @@
// Port-level checker for the multichannel EMA filter, bound to the top level.
`timescale 1ns / 1ps

module ema_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic                         res_ok,
  input logic [ema_pkg::SAMPLE_W-1:0] res_raw,
  input logic [ema_pkg::SAMPLE_W-1:0] res_filt
);
  import ema_pkg::*;

  // reset empties the result register by the next edge
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // back-pressure on input only while a result beat is stuck
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (res_valid && !res_ready))
    else $error("input stalled without a blocked result");

  // unused slot returns zeros
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ok) |-> (res_raw == '0 && res_filt == '0))
    else $error("nonzero payload on unused slot");

  // values never exceed the sample range
  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res_raw >> SAMPLE_BITS) == '0 && (res_filt >> SAMPLE_BITS) == '0))
    else $error("result wider than SAMPLE_BITS");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(res_ok) && $stable(res_raw) && $stable(res_filt)))
    else $error("stalled result beat changed");

endmodule

bind multichannel_ema_filter_top ema_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_ema_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (samples.ready),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_ok    (results.valid_res),
  .res_raw   (results.raw_value),
  .res_filt  (results.filtered_value)
);
